// File: rtl/dlu_pkg.sv
// shared types, constants and helpers of the lu linear solver
package dlu_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int APB_AW = 3;

    typedef logic signed [DATA_W-1:0] q16_t;

    // request commands
    localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
    localparam logic [1:0] CMD_LOAD_RHS  = 2'd1;
    localparam logic [1:0] CMD_SOLVE     = 2'd2;

    // result status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_PIVOT = 1'b1;

    // register map
    localparam logic [APB_AW-3:0] REG_SYSTEM_SIZE = '0;
    localparam logic [4:0]        SIZE_RESET      = 5'd16;

    // clamp a 49-bit difference to the q16.16 range
    function automatic q16_t sat49(input logic signed [48:0] v);
        q16_t r;
        if (v > 49'sh0_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -49'sh0_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/dlu_cmd_if.sv
// request channel of the lu linear solver
interface dlu_cmd_if;
    import dlu_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] row_index;
    logic [3:0] column_index;
    q16_t       entry_value;

    modport source (output valid, command, row_index, column_index, entry_value,
                    input ready);
    modport sink (input valid, command, row_index, column_index, entry_value,
                  output ready);
endinterface

// File: rtl/dlu_res_if.sv
// result channel of the lu linear solver
interface dlu_res_if;
    import dlu_pkg::*;

    logic       valid;
    logic       ready;
    logic [3:0] unknown_index;
    q16_t       solution_value;
    logic       status;
    logic       last;

    modport source (output valid, unknown_index, solution_value, status, last,
                    input ready);
    modport sink (input valid, unknown_index, solution_value, status, last,
                  output ready);
endinterface

// File: rtl/dlu_ram.sv
// generic single write, single read ram with registered read data
module dlu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/dlu_div.sv
// iterative q16.16 divider, one quotient bit a cycle, truncates and saturates
module dlu_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  dlu_pkg::q16_t num,
    input  dlu_pkg::q16_t den,
    output logic         done,
    output dlu_pkg::q16_t quot
);
    import dlu_pkg::*;

    localparam int QW = DATA_W + FRAC_W;

    logic [QW-1:0]     dvd_reg, dvd_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    q16_t              quot_reg, quot_next;

    logic [DATA_W-1:0] num_mag, den_mag;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    assign trial   = {rem_reg[DATA_W-1:0], dvd_reg[QW-1]};
    assign fits    = trial >= {1'b0, dvs_reg};

    // restoring division on magnitudes, sign applied at the end
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start)
        begin
            dvd_next  = {num_mag, {FRAC_W{1'b0}}};
            rem_next  = '0;
            dvs_next  = den_mag;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            cnt_next  = 6'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            rem_next = fits ? trial - {1'b0, dvs_reg} : trial;
            dvd_next = {dvd_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (!neg_reg)
                quot_next = (dvd_reg > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                           : q16_t'(dvd_reg[DATA_W-1:0]);
            else
                quot_next = (dvd_reg > QW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                             : q16_t'(-dvd_reg[DATA_W-1:0]);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// File: rtl/doolittle_lu_linear_solve_top.sv
// lu linear solver top level: stores, sequencer, multiply-subtract datapath
//
//  channel | dir | handshake        | content
//  cmd     | in  | valid/ready      | command, row_index, column_index, entry_value
//  res     | out | valid/ready      | unknown_index, solution_value, status, last
//  apb     | in  | psel/penable     | system_size at byte address 0
//
//  loads are accepted back to back while idle.
//  a solve holds cmd.ready low until its last result sits in the output
//  register; each inner product term runs through ram read, multiply and
//  subtract states, each entry adds init, init wait, finish and write-back
//  states and each division waits on the divider; solve time is set by the
//  single shared multiply-subtract unit and the shared divider.
//  the stores need no clearing after reset; the block is ready at once.
//  a stalled result stalls the sequencer only while a result is pending.
module doolittle_lu_linear_solve_top #(
    parameter int MAX_DIM = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dlu_cmd_if.sink                       cmd,
    dlu_res_if.source                     res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dlu_pkg::APB_AW-1:0]    paddr,
    input  logic [dlu_pkg::DATA_W-1:0]    pwdata,
    output logic [dlu_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import dlu_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int AW = 2 * IW;
    localparam int MD = 1 << AW;
    localparam int VD = 1 << IW;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_INITW = 4'd2;
    localparam logic [3:0] ST_TRD   = 4'd3;
    localparam logic [3:0] ST_TMUL  = 4'd4;
    localparam logic [3:0] ST_TACC  = 4'd5;
    localparam logic [3:0] ST_FIN   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_WB    = 4'd8;
    localparam logic [3:0] ST_ERR   = 4'd9;
    localparam logic [3:0] ST_ORD   = 4'd10;
    localparam logic [3:0] ST_OEMIT = 4'd11;

    // solve phases
    localparam logic [2:0] PH_U   = 3'd0;
    localparam logic [2:0] PH_L   = 3'd1;
    localparam logic [2:0] PH_F   = 3'd2;
    localparam logic [2:0] PH_B   = 3'd3;
    localparam logic [2:0] PH_OUT = 3'd4;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    ph_reg, ph_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] t_reg, t_next;
    logic [CW-1:0] n_reg, n_next;
    logic [4:0]    size_reg, size_next;
    q16_t          s_reg, s_next;
    q16_t          piv_reg, piv_next;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;

    logic          rv_reg, rv_next;
    logic [3:0]    ridx_reg, ridx_next;
    q16_t          rval_reg, rval_next;
    logic          rst_reg, rst_next;
    logic          rlast_reg, rlast_next;

    logic          cmd_acc, slot_free, div_start, div_done, cfg_wr;
    q16_t          div_quot;
    logic [CW-1:0] t_start, t_end, n_clamp;
    logic signed [48:0] diff;

    logic          coef_we, rhs_we, fac_we, work_we;
    logic [AW-1:0] coef_waddr, coef_raddr, fac_waddr, fa_raddr, fb_raddr;
    logic [IW-1:0] rhs_waddr, rhs_raddr, work_waddr, work_raddr;
    q16_t          fac_wdata, work_wdata;
    logic [DATA_W-1:0] coef_rdata, rhs_rdata, fa_rdata, fb_rdata, work_rdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[APB_AW-1:2] == REG_SYSTEM_SIZE) ?
                    DATA_W'(size_reg) : '0;
    assign size_next = (cfg_wr && paddr[APB_AW-1:2] == REG_SYSTEM_SIZE) ?
                       pwdata[4:0] : size_reg;

    // effective system size
    always_comb
    begin
        if (size_reg == 5'd0)
            n_clamp = CW'(1);
        else if ({1'b0, size_reg} > 6'(MAX_DIM))
            n_clamp = CW'(MAX_DIM);
        else
            n_clamp = CW'(size_reg);
    end

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign slot_free = !rv_reg || res.ready;

    // load writes
    assign coef_we    = cmd_acc && cmd.command == CMD_LOAD_COEF &&
                        6'(cmd.row_index) < 6'(MAX_DIM) &&
                        6'(cmd.column_index) < 6'(MAX_DIM);
    assign coef_waddr = {IW'(cmd.row_index), IW'(cmd.column_index)};
    assign rhs_we     = cmd_acc && cmd.command == CMD_LOAD_RHS &&
                        6'(cmd.row_index) < 6'(MAX_DIM);
    assign rhs_waddr  = IW'(cmd.row_index);

    // inner product term range of the current entry
    assign t_start = (ph_reg == PH_B) ? a_reg + CW'(1) : '0;
    assign t_end   = (ph_reg == PH_U || ph_reg == PH_L) ? k_reg :
                     (ph_reg == PH_F) ? a_reg : n_reg;

    // read addresses
    assign coef_raddr = (ph_reg == PH_U) ? {k_reg[IW-1:0], a_reg[IW-1:0]}
                                         : {a_reg[IW-1:0], k_reg[IW-1:0]};
    assign fa_raddr   = (ph_reg == PH_U) ? {k_reg[IW-1:0], t_reg[IW-1:0]}
                                         : {a_reg[IW-1:0], t_reg[IW-1:0]};
    assign fb_raddr   = (state_reg == ST_TRD) ?
                        ((ph_reg == PH_U) ? {t_reg[IW-1:0], a_reg[IW-1:0]}
                                          : {t_reg[IW-1:0], k_reg[IW-1:0]}) :
                        ((ph_reg == PH_B) ? {a_reg[IW-1:0], a_reg[IW-1:0]}
                                          : {k_reg[IW-1:0], k_reg[IW-1:0]});
    assign rhs_raddr  = a_reg[IW-1:0];
    assign work_raddr = (state_reg == ST_TRD) ? t_reg[IW-1:0] : a_reg[IW-1:0];

    // write-back of factors and work vector
    assign fac_we     = (state_reg == ST_WB) && (ph_reg == PH_U || ph_reg == PH_L);
    assign fac_waddr  = (ph_reg == PH_U) ? {k_reg[IW-1:0], a_reg[IW-1:0]}
                                         : {a_reg[IW-1:0], k_reg[IW-1:0]};
    assign fac_wdata  = (ph_reg == PH_U) ? s_reg : div_quot;
    assign work_we    = (state_reg == ST_WB) && (ph_reg == PH_F || ph_reg == PH_B);
    assign work_waddr = a_reg[IW-1:0];
    assign work_wdata = (ph_reg == PH_F) ? s_reg : div_quot;

    // subtract the floored product with saturation
    assign diff = 49'(s_reg) - 49'($signed(prod_reg[2*DATA_W-1:FRAC_W]));

    assign div_start = (state_reg == ST_FIN) && (ph_reg == PH_L || ph_reg == PH_B);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        piv_next   = piv_reg;
        prod_next  = prod_reg;
        rv_next    = rv_reg && !res.ready;
        ridx_next  = ridx_reg;
        rval_next  = rval_reg;
        rst_next   = rst_reg;
        rlast_next = rlast_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && cmd.command == CMD_SOLVE)
                begin
                    n_next     = n_clamp;
                    ph_next    = PH_U;
                    k_next     = '0;
                    a_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
                state_next = ST_INITW;
            ST_INITW:
            begin
                case (ph_reg)
                    PH_F:    s_next = q16_t'(rhs_rdata);
                    PH_B:    s_next = q16_t'(work_rdata);
                    default: s_next = q16_t'(coef_rdata);
                endcase
                piv_next   = q16_t'(fb_rdata);
                t_next     = t_start;
                state_next = (t_start < t_end) ? ST_TRD : ST_FIN;
            end
            ST_TRD:
                state_next = ST_TMUL;
            ST_TMUL:
            begin
                if (ph_reg == PH_F || ph_reg == PH_B)
                    prod_next = q16_t'(fa_rdata) * q16_t'(work_rdata);
                else
                    prod_next = q16_t'(fa_rdata) * q16_t'(fb_rdata);
                state_next = ST_TACC;
            end
            ST_TACC:
            begin
                s_next     = sat49(diff);
                t_next     = t_reg + CW'(1);
                state_next = (t_reg + CW'(1) < t_end) ? ST_TRD : ST_FIN;
            end
            ST_FIN:
                state_next = div_start ? ST_DIV : ST_WB;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                state_next = ST_INIT;
                case (ph_reg)
                    PH_U:
                    begin
                        if (a_reg == k_reg && s_reg == '0)
                            state_next = ST_ERR;
                        else if (a_reg == n_reg - CW'(1))
                        begin
                            if (k_reg == n_reg - CW'(1))
                            begin
                                ph_next = PH_F;
                                a_next  = '0;
                            end
                            else
                            begin
                                ph_next = PH_L;
                                a_next  = k_reg + CW'(1);
                            end
                        end
                        else
                            a_next = a_reg + CW'(1);
                    end
                    PH_L:
                    begin
                        if (a_reg == n_reg - CW'(1))
                        begin
                            ph_next = PH_U;
                            k_next  = k_reg + CW'(1);
                            a_next  = k_reg + CW'(1);
                        end
                        else
                            a_next = a_reg + CW'(1);
                    end
                    PH_F:
                    begin
                        if (a_reg == n_reg - CW'(1))
                            ph_next = PH_B;
                        else
                            a_next = a_reg + CW'(1);
                    end
                    default:
                    begin
                        if (a_reg == '0)
                        begin
                            ph_next    = PH_OUT;
                            state_next = ST_ORD;
                        end
                        else
                            a_next = a_reg - CW'(1);
                    end
                endcase
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    rv_next    = 1'b1;
                    ridx_next  = 4'(k_reg);
                    rval_next  = '0;
                    rst_next   = STATUS_PIVOT;
                    rlast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ORD:
                state_next = ST_OEMIT;
            ST_OEMIT:
            begin
                if (slot_free)
                begin
                    rv_next    = 1'b1;
                    ridx_next  = 4'(a_reg);
                    rval_next  = q16_t'(work_rdata);
                    rst_next   = STATUS_OK;
                    rlast_next = (a_reg == n_reg - CW'(1));
                    if (a_reg == n_reg - CW'(1))
                        state_next = ST_IDLE;
                    else
                    begin
                        a_next     = a_reg + CW'(1);
                        state_next = ST_ORD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_U;
            k_reg     <= '0;
            a_reg     <= '0;
            t_reg     <= '0;
            n_reg     <= CW'(1);
            size_reg  <= SIZE_RESET;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
            a_reg     <= a_next;
            t_reg     <= t_next;
            n_reg     <= n_next;
            size_reg  <= size_next;
            rv_reg    <= rv_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        piv_reg   <= piv_next;
        prod_reg  <= prod_next;
        ridx_reg  <= ridx_next;
        rval_reg  <= rval_next;
        rst_reg   <= rst_next;
        rlast_reg <= rlast_next;
    end

    assign res.valid          = rv_reg;
    assign res.unknown_index  = ridx_reg;
    assign res.solution_value = rval_reg;
    assign res.status         = rst_reg;
    assign res.last           = rlast_reg;

    // coefficient store
    dlu_ram #(.WIDTH(DATA_W), .DEPTH(MD)) u_coef (
        .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(cmd.entry_value),
        .raddr(coef_raddr), .rdata(coef_rdata)
    );

    // factor store, two copies for two reads a cycle
    dlu_ram #(.WIDTH(DATA_W), .DEPTH(MD)) u_fac_a (
        .clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(fac_wdata),
        .raddr(fa_raddr), .rdata(fa_rdata)
    );
    dlu_ram #(.WIDTH(DATA_W), .DEPTH(MD)) u_fac_b (
        .clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(fac_wdata),
        .raddr(fb_raddr), .rdata(fb_rdata)
    );

    // right-hand side store
    dlu_ram #(.WIDTH(DATA_W), .DEPTH(VD)) u_rhs (
        .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(cmd.entry_value),
        .raddr(rhs_raddr), .rdata(rhs_rdata)
    );

    // work vector, y then x
    dlu_ram #(.WIDTH(DATA_W), .DEPTH(VD)) u_work (
        .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    // shared divider
    dlu_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(s_reg), .den(piv_reg),
        .done(div_done), .quot(div_quot)
    );
endmodule

// File: rtl/dlu_checker.sv
// port-level checks of the lu linear solver and their binding
module dlu_port_checks (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic [1:0]                 cmd_command,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [3:0]                 res_unknown_index,
    input logic [dlu_pkg::DATA_W-1:0] res_solution_value,
    input logic                       res_status,
    input logic                       res_last
);
    import dlu_pkg::*;

    // a solve request blocks further requests
    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_command == CMD_SOLVE |=> !cmd_ready)
        else $error("request taken right after a solve");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_solution_value) &&
        $stable(res_unknown_index))
        else $error("stalled result changed");

    // a pivot error is a single zero result
    a_pivot_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == STATUS_PIVOT |-> res_last && res_solution_value == '0)
        else $error("pivot error result malformed");
endmodule

bind doolittle_lu_linear_solve_top dlu_port_checks u_dlu_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(cmd.valid),
    .cmd_ready(cmd.ready),
    .cmd_command(cmd.command),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .res_unknown_index(res.unknown_index),
    .res_solution_value(res.solution_value),
    .res_status(res.status),
    .res_last(res.last)
);
